>>> sv/wsd_pkg.sv
// Shared constants and types for the WebSocket frame deframer.
package wsd_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 64;
   localparam int KEY_W       = 32;
   localparam int EXT_CNT_W   = 4;
   localparam int KEY_IDX_W   = 2;

   // Seven-bit length field codes
   localparam logic [6:0] LEN7_EXT16 = 7'h7E;
   localparam logic [6:0] LEN7_EXT64 = 7'h7F;

   // Extended length byte counts
   localparam logic [EXT_CNT_W-1:0] EXT16_BYTES = 4'd2;
   localparam logic [EXT_CNT_W-1:0] EXT64_BYTES = 4'd8;

   // Index of the last mask key byte
   localparam logic [KEY_IDX_W-1:0] KEY_LAST = 2'd3;

   // One result from the parser
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] payload_byte;
      logic              frame_end;
      logic              empty_frame;
   } result_type;

endpackage

>>> sv/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: input and result registers around the parser.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   req_rx_byte[7:0]
//   rsp      out        rsp_valid/rsp_ready   rsp_payload_byte[7:0], rsp_frame_end,
//                                             rsp_empty_frame
//
// One byte is taken per cycle while req_ready is high.
// The rate is set by the single parse step between the input and result registers.
// Reset is synchronous and returns the parser to the first header byte.
// A stall on rsp holds the result; one more byte waits in the input register,
// then req_ready drops.
module websocket_frame_deframer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [wsd_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [wsd_pkg::BYTE_W-1:0]  rsp_payload_byte,
   output logic                        rsp_frame_end,
   output logic                        rsp_empty_frame
);
   import wsd_pkg::*;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_end_ff;
   logic              out_empty_ff;
   logic              advance;
   result_type        result;

   // Move the held byte on when the result register is free or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   wsd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   // Hold the input byte until the parser takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Load the result register, drop it once transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.valid;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_byte_ff  <= result.payload_byte;
         out_end_ff   <= result.frame_end;
         out_empty_ff <= result.empty_frame;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_frame_end    = out_end_ff;
   assign rsp_empty_frame  = out_empty_ff;

endmodule

>>> sv/wsd_parser.sv
// Header parser, length and key tracking, and payload unmasking.
module wsd_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [wsd_pkg::BYTE_W-1:0]   rx_byte,
   output wsd_pkg::result_type          result
);
   import wsd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   bad_ff, bad_in;
   logic                   masked_ff, masked_in;
   logic [EXT_CNT_W-1:0]   ext_ff, ext_in;
   logic [LEN_W-1:0]       left_ff, left_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [KEY_IDX_W-1:0]   kidx_ff, kidx_in;

   // Work out the next state and the result for the byte at hand
   always_comb begin
      logic [6:0]        len7;
      logic              len_done;
      logic              hdr_done;
      logic [BYTE_W-1:0] kbyte;
      phase_in  = phase_ff;
      bad_in    = bad_ff;
      masked_in = masked_ff;
      ext_in    = ext_ff;
      left_in   = left_ff;
      key_in    = key_ff;
      kidx_in   = kidx_ff;
      result    = '0;
      len7      = rx_byte[6:0];
      len_done  = 1'b0;
      hdr_done  = 1'b0;
      kbyte     = '0;
      case (phase_ff)
         PH_HDR1: begin
            if (bad_ff) begin
               bad_in   = 1'b0;
               phase_in = PH_HDR0;
            end else begin
               masked_in = rx_byte[7];
               if (len7 < LEN7_EXT16) begin
                  left_in  = {{(LEN_W-7){1'b0}}, len7};
                  ext_in   = '0;
                  len_done = 1'b1;
               end else begin
                  left_in  = '0;
                  ext_in   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                  phase_in = PH_EXTLEN;
               end
            end
         end
         PH_EXTLEN: begin
            left_in  = {left_ff[LEN_W-BYTE_W-1:0], rx_byte};
            ext_in   = ext_ff - 1'b1;
            len_done = (ext_in == '0);
         end
         PH_MASK: begin
            key_in = {key_ff[KEY_W-BYTE_W-1:0], rx_byte};
            if (kidx_ff == KEY_LAST) begin
               hdr_done = 1'b1;
            end else begin
               kidx_in = kidx_ff + 1'b1;
            end
         end
         PH_PAYLOAD: begin
            if (masked_ff) begin
               kbyte = key_ff[(KEY_LAST - kidx_ff)*BYTE_W +: BYTE_W];
            end
            kidx_in             = kidx_ff + 1'b1;
            left_in             = left_ff - 1'b1;
            result.valid        = 1'b1;
            result.payload_byte = rx_byte ^ kbyte;
            if (left_in == '0) begin
               phase_in         = PH_HDR0;
               result.frame_end = 1'b1;
            end
         end
         default: begin
            bad_in   = (rx_byte[6:4] != 3'd0);
            phase_in = PH_HDR1;
         end
      endcase

      // Length complete: read the key, or finish the header
      if (len_done) begin
         if (masked_in) begin
            kidx_in  = '0;
            phase_in = PH_MASK;
         end else begin
            hdr_done = 1'b1;
         end
      end

      // Header complete: start the payload, or give the empty marker
      if (hdr_done) begin
         kidx_in = '0;
         if (left_in == '0) begin
            phase_in           = PH_HDR0;
            result.valid       = 1'b1;
            result.frame_end   = 1'b1;
            result.empty_frame = 1'b1;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   // Hold parse state, advance on each byte taken
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         bad_ff    <= 1'b0;
         masked_ff <= 1'b0;
         ext_ff    <= '0;
         left_ff   <= '0;
         key_ff    <= '0;
         kidx_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         bad_ff    <= bad_in;
         masked_ff <= masked_in;
         ext_ff    <= ext_in;
         left_ff   <= left_in;
         key_ff    <= key_in;
         kidx_ff   <= kidx_in;
      end
   end

endmodule
